/* hw/rtl/srp_pkg.sv */
// srp_pkg: shared constants, segment record, status codes, controller states
// and the command and status structs between srp_ctrl and srp_datapath
// no dependencies
package srp_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 16;
    localparam int SEG_IDX_BITS = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_BITS = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [COORD_BITS-1:0] BIN_RESET = COORD_BITS'(1024);

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2
    } res_status_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
    } seg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_CAND_REQ,
        S_CAND_USE,
        S_SPAN_REQ,
        S_SPAN_USE,
        S_CHECK,
        S_REB_REQ,
        S_REB_USE,
        S_REB_FIN,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic        cfg_wr;
        logic        init_seg;
        logic        load_rect;
        logic        rd_cand;
        logic        rd_span;
        logic        rd_reb;
        logic        take_cand;
        logic        next_cand;
        logic        span_acc;
        logic        start_reb;
        logic        emit_new;
        logic        emit_old;
        logic        finish_reb;
        logic        res_load;
        res_status_t res_code;
        logic        out_load;
    } srp_cmd_t;

    typedef struct packed {
        logic cfg_idx_ok;
        logic rect_zero;
        logic i_end;
        logic cand_over;
        logic k_end;
        logic span_past;
        logic too_high;
        logic store_full;
        logic at_i;
        logic out_free;
    } srp_stat_t;

endpackage

/* hw/rtl/srp_ctrl.sv */
// srp_ctrl: sequencer for scan, span measure and skyline rebuild
// depends on srp_pkg
module srp_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  srp_pkg::srp_stat_t                stat,
    output srp_pkg::srp_cmd_t                 cmd
);
    import srp_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_NOFIT;
        cfg_ready  = (state_reg == S_IDLE);
        in_stall   = (state_reg != S_IDLE) || cfg_valid;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_seg = 1'b1;
                state_next   = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (stat.cfg_idx_ok)
                    begin
                        cmd.cfg_wr = 1'b1;
                        state_next = S_INIT;
                    end
                end
                else if (in_valid)
                begin
                    cmd.load_rect = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (stat.rect_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_NOFIT;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_CAND_REQ;
                end
            end
            S_CAND_REQ:
            begin
                if (stat.i_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_NOFIT;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_cand = 1'b1;
                    state_next  = S_CAND_USE;
                end
            end
            S_CAND_USE:
            begin
                if (stat.cand_over)
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = S_CAND_REQ;
                end
                else
                begin
                    cmd.take_cand = 1'b1;
                    state_next    = S_SPAN_REQ;
                end
            end
            S_SPAN_REQ:
            begin
                if (stat.k_end)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.rd_span = 1'b1;
                    state_next  = S_SPAN_USE;
                end
            end
            S_SPAN_USE:
            begin
                if (stat.span_past)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.span_acc = 1'b1;
                    state_next   = S_SPAN_REQ;
                end
            end
            S_CHECK:
            begin
                if (stat.too_high)
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = S_CAND_REQ;
                end
                else if (stat.store_full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.start_reb = 1'b1;
                    state_next    = S_REB_REQ;
                end
            end
            S_REB_REQ:
            begin
                if (stat.k_end)
                begin
                    state_next = S_REB_FIN;
                end
                else
                begin
                    cmd.rd_reb = 1'b1;
                    state_next = S_REB_USE;
                end
            end
            S_REB_USE:
            begin
                if (stat.at_i)
                begin
                    cmd.emit_new = 1'b1;
                end
                else
                begin
                    cmd.emit_old = 1'b1;
                    state_next   = S_REB_REQ;
                end
            end
            S_REB_FIN:
            begin
                cmd.finish_reb = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

/* hw/rtl/srp_datapath.sv */
// srp_datapath: double-banked segment memory, scan registers, merge stage
// and result registers
// depends on srp_pkg
module srp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [srp_pkg::COORD_BITS-1:0]    cfg_data,
    input  logic [srp_pkg::COORD_BITS-1:0]    rect_width,
    input  logic [srp_pkg::COORD_BITS-1:0]    rect_height,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [srp_pkg::COORD_BITS-1:0]    place_x,
    output logic [srp_pkg::COORD_BITS-1:0]    place_y,
    input  srp_pkg::srp_cmd_t                 cmd,
    output srp_pkg::srp_stat_t                stat
);
    import srp_pkg::*;

    localparam int CB = COORD_BITS;

    seg_t mem [2*MAX_SEGMENTS];

    logic                    cur_reg;
    logic [SEG_CNT_BITS-1:0] count_reg;
    logic [CB-1:0]           bw_reg;
    logic [CB-1:0]           bh_reg;
    logic                    out_valid_reg;
    logic                    pend_valid_reg;
    logic                    pend_valid_next;
    logic                    new_done_reg;

    logic [CB-1:0]           w_reg;
    logic [CB-1:0]           h_reg;
    logic [SEG_CNT_BITS-1:0] i_reg;
    logic [SEG_CNT_BITS-1:0] k_reg;
    logic [SEG_CNT_BITS-1:0] j_reg;
    logic [SEG_CNT_BITS-1:0] j_next;
    logic [CB-1:0]           xc_reg;
    logic [CB-1:0]           end_reg;
    logic [CB-1:0]           ymax_reg;
    logic [CB-1:0]           newtop_reg;
    seg_t                    rd_reg;
    seg_t                    pend_reg;
    seg_t                    pend_next;
    res_status_t             res_status_reg;
    logic [CB-1:0]           res_x_reg;
    logic [CB-1:0]           res_y_reg;
    res_status_t             out_status_reg;
    logic [CB-1:0]           out_x_reg;
    logic [CB-1:0]           out_y_reg;

    logic                    rd_en;
    logic [SEG_IDX_BITS-1:0] rd_idx;
    logic                    wr_en;
    logic [SEG_IDX_BITS:0]   wr_addr;
    seg_t                    wr_data;
    logic                    emit_en;
    seg_t                    emit_seg;
    logic                    merge;
    logic                    wr_pend;
    logic [CB:0]             rd_end;

    assign rd_end = {1'b0, rd_reg.x} + {1'b0, rd_reg.width};

    always_comb
    begin
        rd_en  = cmd.rd_cand || cmd.rd_span || cmd.rd_reb;
        rd_idx = cmd.rd_cand ? i_reg[SEG_IDX_BITS-1:0] : k_reg[SEG_IDX_BITS-1:0];

        emit_en  = 1'b0;
        emit_seg = rd_reg;
        if (cmd.emit_new)
        begin
            emit_en  = 1'b1;
            emit_seg = '{x: xc_reg, top: newtop_reg, width: w_reg};
        end
        else if (cmd.emit_old)
        begin
            if ((k_reg < i_reg) || (rd_reg.x >= end_reg))
            begin
                emit_en = 1'b1;
            end
            else if (rd_end > {1'b0, end_reg})
            begin
                emit_en  = 1'b1;
                emit_seg = '{x: end_reg, top: rd_reg.top,
                             width: CB'(rd_end - {1'b0, end_reg})};
            end
        end
        merge   = pend_valid_reg && (emit_seg.top == pend_reg.top);
        wr_pend = emit_en && pend_valid_reg && !merge;

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        j_next          = j_reg;
        if (emit_en)
        begin
            if (merge)
            begin
                pend_next.width = CB'(pend_reg.width + emit_seg.width);
            end
            else
            begin
                pend_next       = emit_seg;
                pend_valid_next = 1'b1;
            end
            if (wr_pend)
            begin
                j_next = SEG_CNT_BITS'(j_reg + 1'b1);
            end
        end

        wr_en   = 1'b0;
        wr_addr = {cur_reg, SEG_IDX_BITS'(0)};
        wr_data = '{x: '0, top: '0, width: bw_reg};
        if (cmd.init_seg)
        begin
            wr_en = 1'b1;
        end
        else if (wr_pend || cmd.finish_reb)
        begin
            wr_en   = 1'b1;
            wr_addr = {~cur_reg, j_reg[SEG_IDX_BITS-1:0]};
            wr_data = pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[{cur_reg, rd_idx}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= 1'b0;
            count_reg      <= SEG_CNT_BITS'(1);
            bw_reg         <= BIN_RESET;
            bh_reg         <= BIN_RESET;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            new_done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                if (cfg_index == CFG_BIN_WIDTH)
                begin
                    bw_reg <= cfg_data;
                end
                else
                begin
                    bh_reg <= cfg_data;
                end
            end
            if (cmd.init_seg)
            begin
                count_reg <= SEG_CNT_BITS'(1);
            end
            if (cmd.start_reb)
            begin
                pend_valid_reg <= 1'b0;
                new_done_reg   <= 1'b0;
            end
            else
            begin
                pend_valid_reg <= pend_valid_next;
            end
            if (cmd.emit_new)
            begin
                new_done_reg <= 1'b1;
            end
            if (cmd.finish_reb)
            begin
                count_reg <= SEG_CNT_BITS'(j_reg + 1'b1);
                cur_reg   <= ~cur_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rect)
        begin
            w_reg <= rect_width;
            h_reg <= rect_height;
            i_reg <= '0;
        end
        if (cmd.next_cand)
        begin
            i_reg <= SEG_CNT_BITS'(i_reg + 1'b1);
        end
        if (cmd.take_cand)
        begin
            xc_reg   <= rd_reg.x;
            end_reg  <= CB'(rd_reg.x + w_reg);
            ymax_reg <= rd_reg.top;
            k_reg    <= SEG_CNT_BITS'(i_reg + 1'b1);
        end
        if (cmd.span_acc)
        begin
            if (rd_reg.top > ymax_reg)
            begin
                ymax_reg <= rd_reg.top;
            end
            k_reg <= SEG_CNT_BITS'(k_reg + 1'b1);
        end
        if (cmd.start_reb)
        begin
            newtop_reg     <= CB'(ymax_reg + h_reg);
            k_reg          <= '0;
            j_reg          <= '0;
            res_status_reg <= ST_PLACED;
            res_x_reg      <= xc_reg;
            res_y_reg      <= ymax_reg;
        end
        if (cmd.emit_old)
        begin
            k_reg <= SEG_CNT_BITS'(k_reg + 1'b1);
        end
        if (cmd.emit_new || cmd.emit_old)
        begin
            pend_reg <= pend_next;
            j_reg    <= j_next;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    always_comb
    begin
        stat.cfg_idx_ok = (cfg_index == CFG_BIN_WIDTH) || (cfg_index == CFG_BIN_HEIGHT);
        stat.rect_zero  = (w_reg == '0) || (h_reg == '0);
        stat.i_end      = (i_reg == count_reg);
        stat.cand_over  = ({1'b0, rd_reg.x} + {1'b0, w_reg}) > {1'b0, bw_reg};
        stat.k_end      = (k_reg == count_reg);
        stat.span_past  = (rd_reg.x >= end_reg);
        stat.too_high   = ({1'b0, ymax_reg} + {1'b0, h_reg}) > {1'b0, bh_reg};
        stat.store_full = (count_reg >= SEG_CNT_BITS'(MAX_SEGMENTS));
        stat.at_i       = (k_reg == i_reg) && !new_done_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign place_x   = out_x_reg;
    assign place_y   = out_y_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= SEG_CNT_BITS'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while waiting");

    a_rebuild_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_reb |-> (j_reg < SEG_CNT_BITS'(MAX_SEGMENTS)) && pend_valid_reg)
        else $error("rebuild overflowed segment store");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_reb |=> (cur_reg != $past(cur_reg)))
        else $error("bank not swapped after rebuild");

endmodule

/* hw/rtl/skyline_rect_packer_unit.sv */
// skyline_rect_packer_unit: top level of the skyline rectangle packer
// depends on srp_pkg, srp_ctrl, srp_datapath
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_stall   | rect_width, rect_height
//  out     | out       | out_valid/out_stall | status, place_x, place_y
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one request at a time; the candidate scan, each span measure and the rebuild read
// each segment through a request state and then a use state, and accept, checks, the new segment,
// rebuild close-out and result hand-off add states of their own
// the segment memory's single registered read port is why each read needs its use state
// after reset and after each bin width or height write the init state loads the floor segment
// a waiting result holds in the output register; the next request is taken meanwhile
// and its own result then waits in the done state until the register frees
module skyline_rect_packer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [srp_pkg::COORD_BITS-1:0]    rect_width,
    input  logic [srp_pkg::COORD_BITS-1:0]    rect_height,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [srp_pkg::COORD_BITS-1:0]    place_x,
    output logic [srp_pkg::COORD_BITS-1:0]    place_y,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [srp_pkg::COORD_BITS-1:0]    cfg_data
);
    import srp_pkg::*;

    srp_cmd_t  cmd;
    srp_stat_t stat;

    srp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .place_x     (place_x),
        .place_y     (place_y),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

/* verif/skyline_rect_packer_unit_tb.sv */
// skyline_rect_packer_unit_tb: self-checking testbench for the skyline rectangle packer
// keeps its own skyline model, drives bursty requests and compares every placement result
// depends on srp_pkg and skyline_rect_packer_unit
`timescale 1ns / 100ps

module skyline_rect_packer_unit_tb;
    import srp_pkg::*;

    localparam int CW        = COORD_BITS;
    localparam longint LIMIT = 100_000_000;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    typedef struct {
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } rect_req_t;

    typedef struct {
        res_status_t   st;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } placement_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [CW-1:0] rect_width = '0;
    logic [CW-1:0] rect_height = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] status;
    logic [CW-1:0] place_x;
    logic [CW-1:0] place_y;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    rect_req_t  pending_rects[$];
    placement_t expected_placements[$];
    int         errors = 0;
    longint     cycles = 0;

    // skyline model
    longint unsigned bin_w, bin_h;
    longint unsigned sky_x[MAX_SEGMENTS], sky_top[MAX_SEGMENTS], sky_w[MAX_SEGMENTS];
    int sky_n;

    skyline_rect_packer_unit dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void clear_sky();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            sky_x[k] = 0;
            sky_top[k] = 0;
            sky_w[k] = 0;
        end
        sky_w[0] = bin_w & 16'hffff;
        sky_n = 1;
    endfunction

    function automatic void drop_seg(int pos);
        for (int k = pos; k + 1 < sky_n; k++)
        begin
            sky_x[k] = sky_x[k+1];
            sky_top[k] = sky_top[k+1];
            sky_w[k] = sky_w[k+1];
        end
        sky_n--;
        sky_x[sky_n] = 0;
        sky_top[sky_n] = 0;
        sky_w[sky_n] = 0;
    endfunction

    function automatic longint unsigned span_height(int i, longint unsigned w);
        longint unsigned y = 0;
        longint unsigned rem = w;
        int k = i;
        while (rem > 0 && k < sky_n)
        begin
            if (sky_top[k] > y)
                y = sky_top[k];
            rem -= (sky_w[k] < rem) ? sky_w[k] : rem;
            k++;
        end
        return y;
    endfunction

    function automatic placement_t pack_rect(rect_req_t r);
        placement_t      p;
        longint unsigned w = r.w;
        longint unsigned h = r.h;
        longint unsigned x, y, fin, ov;
        int k;
        p.st = ST_NOFIT;
        p.x = '0;
        p.y = '0;
        if (w == 0 || h == 0)
            return p;
        for (int i = 0; i < sky_n; i++)
        begin
            x = sky_x[i];
            if (x + w > bin_w)
                continue;
            y = span_height(i, w);
            if (y + h > bin_h)
                continue;
            if (sky_n >= MAX_SEGMENTS)
            begin
                p.st = ST_FULL;
                return p;
            end
            for (k = sky_n; k > i; k--)
            begin
                sky_x[k] = sky_x[k-1];
                sky_top[k] = sky_top[k-1];
                sky_w[k] = sky_w[k-1];
            end
            sky_x[i] = x & 16'hffff;
            sky_top[i] = (y + h) & 16'hffff;
            sky_w[i] = w;
            sky_n++;
            fin = x + w;
            k = i + 1;
            while (k < sky_n)
            begin
                if (sky_x[k] >= fin)
                    break;
                ov = fin - sky_x[k];
                if (ov >= sky_w[k])
                begin
                    drop_seg(k);
                    continue;
                end
                sky_w[k] -= ov;
                sky_x[k] = fin & 16'hffff;
                break;
            end
            k = 0;
            while (k + 1 < sky_n)
            begin
                if (sky_top[k] == sky_top[k+1])
                begin
                    sky_w[k] = (sky_w[k] + sky_w[k+1]) & 16'hffff;
                    drop_seg(k + 1);
                end
                else
                    k++;
            end
            p.st = ST_PLACED;
            p.x = x[CW-1:0];
            p.y = y[CW-1:0];
            return p;
        end
        return p;
    endfunction

    task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // request driver, bursts with gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        logic      nxt;
        rect_req_t r;
        if (in_valid && !in_stall)
        begin
            r = pending_rects.pop_front();
            expected_placements.insert(expected_placements.size(), pack_rect(r));
        end
        nxt = 0;
        if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_rects.size() > 0 && rst_n)
            begin
                nxt = 1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end
            end
            in_valid <= nxt;
            if (nxt)
            begin
                rect_width <= pending_rects[0].w;
                rect_height <= pending_rects[0].h;
            end
        end
    end

    // result monitor and receiver stall pattern
    int stall_pct = 0;
    always @(posedge clk)
    begin
        placement_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_placements.size() == 0)
            begin
                report("unexpected result status", CW'(status), '0);
            end
            else
            begin
                e = expected_placements.pop_front();
                if (status !== e.st)
                    report("status", CW'(status), CW'(e.st));
                if (place_x !== e.x)
                    report("place_x", place_x, e.x);
                if (place_y !== e.y)
                    report("place_y", place_y, e.y);
            end
        end
        if (cycles % 97 == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 85);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] d);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == CFG_BIN_WIDTH)
        begin
            bin_w = d;
            clear_sky();
        end
        else if (idx == CFG_BIN_HEIGHT)
        begin
            bin_h = d;
            clear_sky();
        end
    endtask

    task automatic queue_rect(int w, int h);
        rect_req_t r;
        r.w = w[CW-1:0];
        r.h = h[CW-1:0];
        pending_rects.insert(pending_rects.size(), r);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_rects.size() != 0 || expected_placements.size() != 0 || in_valid);
        repeat (20) @(posedge clk);
    endtask

    function automatic int pick_dim(longint unsigned lim);
        int m;
        m = (lim < 4) ? 1 : int'(lim / 3);
        case ($urandom_range(0, 49))
            0: return 0;
            1, 2: return $urandom_range(0, 65535);
            3: return 65535;
            default: return $urandom_range(1, m);
        endcase
    endfunction

    function automatic int pick_bin();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return 65535;
            3: return $urandom_range(0, 65535);
            default: return $urandom_range(8, 300);
        endcase
    endfunction

    initial
    begin
        bin_w = BIN_RESET;
        bin_h = BIN_RESET;
        clear_sky();
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, zero sizes, exact fits, span over several segments
        queue_rect(0, 5);
        queue_rect(5, 0);
        queue_rect(65535, 1);
        queue_rect(1, 65535);
        queue_rect(1024, 1025);
        queue_rect(100, 50);
        queue_rect(200, 20);
        queue_rect(300, 80);
        queue_rect(250, 10);
        queue_rect(600, 60);
        queue_rect(174, 30);
        queue_rect(1024, 900);
        queue_rect(1024, 10);
        queue_rect(1, 1);
        drain();

        write_reg(CFG_BIN_WIDTH, 16'd0);
        queue_rect(1, 1);
        drain();
        write_reg(CFG_BIN_WIDTH, 16'd65535);
        write_reg(CFG_BIN_HEIGHT, 16'd0);
        queue_rect(1, 1);
        drain();
        write_reg(CFG_BIN_HEIGHT, 16'd65535);
        queue_rect(65535, 65535);
        queue_rect(1, 1);
        drain();
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hffff);
        queue_rect(7, 7);
        drain();

        // alternating column heights fill the segment store
        write_reg(CFG_BIN_WIDTH, 16'd1024);
        write_reg(CFG_BIN_HEIGHT, 16'd4);
        for (int i = 0; i < 72; i++)
            queue_rect(1, (i % 2 == 0) ? 4 : 3);
        queue_rect(2000, 1);
        drain();

        for (int ph = 0; ph < 13; ph++)
        begin
            write_reg(CFG_BIN_WIDTH, CW'(pick_bin()));
            write_reg(CFG_BIN_HEIGHT, CW'(pick_bin()));
            for (int i = 0; i < 127; i++)
                queue_rect(pick_dim(bin_w), pick_dim(bin_h));
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/srp_pkg.sv
hw/rtl/srp_ctrl.sv
hw/rtl/srp_datapath.sv
hw/rtl/skyline_rect_packer_unit.sv
verif/skyline_rect_packer_unit_tb.sv
